// ----- hw/rtl/stl_pkg.sv -----
package stl_pkg;

    // Field widths of a result item
    localparam int POS_BITS  = 32;
    localparam int LINE_BITS = 24;
    localparam int KIND_BITS = 6;

    localparam logic [POS_BITS-1:0]  POS_TOP  = {POS_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_TOP = {LINE_BITS{1'b1}};

    // Results per input item and the result queue behind the scanner
    localparam int MAX_RES   = 3;
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);
    localparam int RQ_DEPTH  = 4;
    localparam int RQ_PTR_W  = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W  = $clog2(RQ_DEPTH + 1);

    localparam int TOK_FIELDS_W = KIND_BITS + 2 * POS_BITS + LINE_BITS;
    localparam int OUT_TDATA_W  = ((TOK_FIELDS_W + 7) / 8) * 8;

    // Carriage return has no string escape
    localparam logic [7:0] BYTE_CR = 8'h0D;

    // Token kinds
    localparam logic [KIND_BITS-1:0] K_END      = 6'd0;
    localparam logic [KIND_BITS-1:0] K_IDENT    = 6'd1;
    localparam logic [KIND_BITS-1:0] K_NUM      = 6'd2;
    localparam logic [KIND_BITS-1:0] K_STR      = 6'd3;
    localparam logic [KIND_BITS-1:0] K_KW_BASE  = 6'd4;
    localparam logic [KIND_BITS-1:0] K_HASH     = 6'd9;
    localparam logic [KIND_BITS-1:0] K_LPAREN   = 6'd10;
    localparam logic [KIND_BITS-1:0] K_RPAREN   = 6'd11;
    localparam logic [KIND_BITS-1:0] K_LBRACE   = 6'd12;
    localparam logic [KIND_BITS-1:0] K_RBRACE   = 6'd14;
    localparam logic [KIND_BITS-1:0] K_LBRACK   = 6'd16;
    localparam logic [KIND_BITS-1:0] K_RBRACK   = 6'd17;
    localparam logic [KIND_BITS-1:0] K_SEMI     = 6'd18;
    localparam logic [KIND_BITS-1:0] K_COMMA    = 6'd19;
    localparam logic [KIND_BITS-1:0] K_DOT      = 6'd20;
    localparam logic [KIND_BITS-1:0] K_MINUS    = 6'd21;
    localparam logic [KIND_BITS-1:0] K_AMPARROW = 6'd23;
    localparam logic [KIND_BITS-1:0] K_PLUS     = 6'd24;
    localparam logic [KIND_BITS-1:0] K_SLASH    = 6'd25;
    localparam logic [KIND_BITS-1:0] K_STAR     = 6'd26;
    localparam logic [KIND_BITS-1:0] K_BANG     = 6'd27;
    localparam logic [KIND_BITS-1:0] K_ASSIGN   = 6'd29;
    localparam logic [KIND_BITS-1:0] K_LT       = 6'd31;
    localparam logic [KIND_BITS-1:0] K_GT       = 6'd33;
    localparam logic [KIND_BITS-1:0] K_COLON    = 6'd35;
    localparam logic [KIND_BITS-1:0] K_BAD      = 6'd36;
    localparam logic [KIND_BITS-1:0] K_UNTERM   = 6'd37;

    // Held one-char punctuators: opener, completing byte, short kind (long = short + 1)
    localparam int PEND_NUM = 7;
    localparam logic [7:0] PEND_OPEN [PEND_NUM] = '{"{", "}", "-", "!", "=", "<", ">"};
    localparam logic [7:0] PEND_SECOND [PEND_NUM] = '{"{", "}", ">", "=", "=", "=", "="};
    localparam logic [KIND_BITS-1:0] PEND_SHORT [PEND_NUM] =
        '{K_LBRACE, K_RBRACE, K_MINUS, K_BANG, K_ASSIGN, K_LT, K_GT};

    // Keywords
    localparam int KW_NUM = 5;
    localparam logic [3:0] KW_LEN [KW_NUM] = '{4'd6, 4'd8, 4'd3, 4'd7, 4'd6};
    localparam logic [7:0] KW_TEXT [KW_NUM][8] = '{
        '{"L", "i", "s", "t", "e", "n", 8'h00, 8'h00},
        '{"D", "e", "l", "e", "g", "a", "t", "e"},
        '{"V", "i", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"A", "n", "i", "m", "a", "t", "e", 8'h00},
        '{"R", "o", "u", "t", "e", "r", 8'h00, 8'h00}
    };

    typedef enum logic [3:0] {
        M_IDLE,
        M_SLASH,
        M_LINECMT,
        M_BLOCK,
        M_BLOCKSTAR,
        M_IDENT,
        M_INT,
        M_DOT,
        M_FRAC,
        M_STR,
        M_AMP,
        M_AMPDASH,
        M_PEND
    } scan_mode_t;

    typedef struct packed {
        scan_mode_t            mode;
        logic [2:0]            pend_sel;
        logic                  quote_single;
        logic [POS_BITS-1:0]   pos;
        logic [POS_BITS-1:0]   tok_begin;
        logic [LINE_BITS-1:0]  line;
        logic [KW_NUM-1:0]     kw_cand;
        logic [3:0]            kw_idx;
    } stl_state_t;

    localparam stl_state_t ST_RESET = '{
        mode:         M_IDLE,
        pend_sel:     3'd0,
        quote_single: 1'b0,
        pos:          '0,
        tok_begin:    '0,
        line:         LINE_BITS'(1),
        kw_cand:      '1,
        kw_idx:       4'd0
    };

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [POS_BITS-1:0]   start;
        logic [POS_BITS-1:0]   length;
        logic [LINE_BITS-1:0]  line;
    } stl_tok_t;

    typedef struct packed {
        stl_tok_t  tok;
        logic      last;
    } stl_entry_t;

    // Results of one item, handed from the scanner to the queue
    typedef struct packed {
        logic [RES_CNT_W-1:0]        count;
        stl_tok_t [MAX_RES-1:0]      tok;
    } stl_push_t;

    function automatic stl_tok_t make_tok(input logic [KIND_BITS-1:0] kind,
                                          input logic [POS_BITS-1:0] start,
                                          input logic [POS_BITS-1:0] length,
                                          input logic [LINE_BITS-1:0] line);
        stl_tok_t t;
        t.kind   = kind;
        t.start  = start;
        t.length = length;
        t.line   = line;
        return t;
    endfunction

    // Drop the keywords that the byte at position idx rules out
    function automatic logic [KW_NUM-1:0] kw_feed(input logic [KW_NUM-1:0] cand,
                                                  input logic [3:0] idx,
                                                  input logic [7:0] c);
        logic [KW_NUM-1:0] r;
        r = cand;
        for (int k = 0; k < KW_NUM; k++) begin
            if (idx >= KW_LEN[k] || KW_TEXT[k][idx[2:0]] != c) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    // First surviving keyword of matching length, else a plain identifier
    function automatic logic [KIND_BITS-1:0] kw_kind(input logic [KW_NUM-1:0] cand,
                                                     input logic [3:0] idx);
        logic [KIND_BITS-1:0] r;
        r = K_IDENT;
        for (int k = KW_NUM - 1; k >= 0; k--) begin
            if (cand[k] && KW_LEN[k] == idx) begin
                r = K_KW_BASE + KIND_BITS'(k);
            end
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/stl_step.sv -----
module stl_step
    import stl_pkg::*;
(
    input  stl_state_t  st,
    input  logic [7:0]  byte_value,
    input  logic        end_of_input,
    output stl_state_t  st_next,
    output stl_push_t   push
);

    logic [7:0]           c;
    logic [POS_BITS-1:0]  p, p_inc, p_dec, span_p, span_pi, span_d;
    logic [LINE_BITS-1:0] line_inc;
    logic                 is_letter, is_digit, is_space;
    logic [7:0]           quote_char;

    // between-token decode of the current byte
    scan_mode_t           fi_mode;
    logic [2:0]           fi_sel;
    logic                 fi_quote_set, fi_quote, fi_begin_set, fi_bump, fi_ident, fi_emit;
    logic [KIND_BITS-1:0] fi_kind;
    logic                 pend_hit;
    logic [2:0]           pend_idx;

    logic                 restart;

    // held-token flush and the extra result
    logic [RES_CNT_W-1:0] f_cnt, use_cnt;
    stl_tok_t             f0, f1, ex_tok;
    logic                 ex_v;

    assign c          = byte_value;
    assign p          = st.pos;
    assign p_inc      = (p == POS_TOP) ? p : p + 1'b1;
    assign p_dec      = (p != '0) ? p - 1'b1 : '0;
    assign span_p     = (p > st.tok_begin) ? p - st.tok_begin : '0;
    assign span_pi    = (p_inc > st.tok_begin) ? p_inc - st.tok_begin : '0;
    assign span_d     = (p_dec > st.tok_begin) ? p_dec - st.tok_begin : '0;
    assign line_inc   = (st.line == LINE_TOP) ? st.line : st.line + 1'b1;
    assign is_letter  = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    assign is_digit   = (c >= "0" && c <= "9");
    assign is_space   = (c == " " || c == "\t" || c == BYTE_CR);
    assign quote_char = st.quote_single ? 8'h27 : 8'h22;

    always_comb begin
        fi_mode      = M_IDLE;
        fi_sel       = 3'd0;
        fi_quote_set = 1'b0;
        fi_quote     = 1'b0;
        fi_begin_set = 1'b1;
        fi_bump      = 1'b0;
        fi_ident     = 1'b0;
        fi_emit      = 1'b0;
        fi_kind      = K_BAD;
        pend_hit     = 1'b0;
        pend_idx     = 3'd0;
        for (int k = PEND_NUM - 1; k >= 0; k--) begin
            if (c == PEND_OPEN[k]) begin
                pend_hit = 1'b1;
                pend_idx = 3'(k);
            end
        end
        if (is_space) begin
            fi_begin_set = 1'b0;
        end else if (c == "\n") begin
            fi_begin_set = 1'b0;
            fi_bump      = 1'b1;
        end else if (is_letter) begin
            fi_mode  = M_IDENT;
            fi_ident = 1'b1;
        end else if (is_digit) begin
            fi_mode = M_INT;
        end else if (pend_hit) begin
            fi_mode = M_PEND;
            fi_sel  = pend_idx;
        end else begin
            unique case (c)
                "/": fi_mode = M_SLASH;
                "&": fi_mode = M_AMP;
                8'h22: begin
                    fi_mode      = M_STR;
                    fi_quote_set = 1'b1;
                    fi_quote     = 1'b0;
                end
                8'h27: begin
                    fi_mode      = M_STR;
                    fi_quote_set = 1'b1;
                    fi_quote     = 1'b1;
                end
                "#": begin fi_emit = 1'b1; fi_kind = K_HASH;   end
                "(": begin fi_emit = 1'b1; fi_kind = K_LPAREN; end
                ")": begin fi_emit = 1'b1; fi_kind = K_RPAREN; end
                "[": begin fi_emit = 1'b1; fi_kind = K_LBRACK; end
                "]": begin fi_emit = 1'b1; fi_kind = K_RBRACK; end
                ";": begin fi_emit = 1'b1; fi_kind = K_SEMI;   end
                ",": begin fi_emit = 1'b1; fi_kind = K_COMMA;  end
                ".": begin fi_emit = 1'b1; fi_kind = K_DOT;    end
                "+": begin fi_emit = 1'b1; fi_kind = K_PLUS;   end
                "*": begin fi_emit = 1'b1; fi_kind = K_STAR;   end
                ":": begin fi_emit = 1'b1; fi_kind = K_COLON;  end
                default: begin
                    fi_emit = 1'b1;
                    fi_kind = K_BAD;
                end
            endcase
        end
    end

    // Byte that does not continue the held token: flush it and rescan the byte
    always_comb begin
        unique case (st.mode)
            M_PEND:      restart = (c != PEND_SECOND[st.pend_sel]);
            M_SLASH:     restart = (c != "/" && c != "*");
            M_LINECMT,
            M_BLOCK,
            M_BLOCKSTAR,
            M_STR:       restart = 1'b0;
            M_IDENT:     restart = !(is_letter || is_digit || c == "-");
            M_INT:       restart = !(is_digit || c == ".");
            M_DOT,
            M_FRAC:      restart = !is_digit;
            M_AMP:       restart = (c != "-");
            M_AMPDASH:   restart = (c != ">");
            default:     restart = 1'b1;
        endcase
    end

    // Next state
    always_comb begin
        st_next = st;
        if (end_of_input) begin
            st_next = ST_RESET;
        end else begin
            st_next.pos = p_inc;
            if (restart) begin
                st_next.mode     = fi_mode;
                st_next.pend_sel = fi_sel;
                if (fi_quote_set) begin
                    st_next.quote_single = fi_quote;
                end
                if (fi_begin_set) begin
                    st_next.tok_begin = p;
                end
                if (fi_bump) begin
                    st_next.line = line_inc;
                end
                if (fi_ident) begin
                    st_next.kw_cand = kw_feed('1, 4'd0, c);
                    st_next.kw_idx  = 4'd1;
                end
            end else begin
                unique case (st.mode)
                    M_PEND:    st_next.mode = M_IDLE;
                    M_SLASH:   st_next.mode = (c == "/") ? M_LINECMT : M_BLOCK;
                    M_LINECMT: begin
                        if (c == "\n") begin
                            st_next.line = line_inc;
                            st_next.mode = M_IDLE;
                        end
                    end
                    M_BLOCK,
                    M_BLOCKSTAR: begin
                        if (st.mode == M_BLOCKSTAR && c == "/") begin
                            st_next.mode = M_IDLE;
                        end else if (c == "*") begin
                            st_next.mode = M_BLOCKSTAR;
                        end else begin
                            if (c == "\n") begin
                                st_next.line = line_inc;
                            end
                            st_next.mode = M_BLOCK;
                        end
                    end
                    M_IDENT: begin
                        st_next.kw_cand = kw_feed(st.kw_cand, st.kw_idx, c);
                        st_next.kw_idx  = (st.kw_idx == 4'd15) ? st.kw_idx : st.kw_idx + 1'b1;
                    end
                    M_INT: begin
                        if (c == ".") begin
                            st_next.mode = M_DOT;
                        end
                    end
                    M_DOT:     st_next.mode = M_FRAC;
                    M_STR: begin
                        if (c == quote_char) begin
                            st_next.mode = M_IDLE;
                        end else if (c == "\n") begin
                            st_next.line = line_inc;
                        end
                    end
                    M_AMP:     st_next.mode = M_AMPDASH;
                    M_AMPDASH: st_next.mode = M_IDLE;
                    default:   st_next.mode = st.mode;
                endcase
            end
        end
    end

    // Result items: flushed token(s) first, then the one this byte makes
    always_comb begin
        f_cnt = '0;
        f0    = make_tok(K_END, st.tok_begin, span_p, st.line);
        f1    = make_tok(K_DOT, p_dec, POS_BITS'(1), st.line);
        unique case (st.mode)
            M_PEND: begin
                f_cnt   = RES_CNT_W'(1);
                f0.kind = PEND_SHORT[st.pend_sel];
            end
            M_SLASH: begin
                f_cnt   = RES_CNT_W'(1);
                f0.kind = K_SLASH;
            end
            M_IDENT: begin
                f_cnt   = RES_CNT_W'(1);
                f0.kind = kw_kind(st.kw_cand, st.kw_idx);
            end
            M_INT,
            M_FRAC: begin
                f_cnt   = RES_CNT_W'(1);
                f0.kind = K_NUM;
            end
            M_DOT: begin
                // the dot was not followed by a digit: number, then the dot alone
                f_cnt     = RES_CNT_W'(2);
                f0.kind   = K_NUM;
                f0.length = span_d;
            end
            M_AMP,
            M_AMPDASH: begin
                f_cnt   = RES_CNT_W'(1);
                f0.kind = K_BAD;
            end
            M_STR: begin
                f_cnt   = RES_CNT_W'(1);
                f0.kind = K_UNTERM;
            end
            default: f_cnt = '0;
        endcase

        ex_v    = 1'b0;
        ex_tok  = make_tok(fi_kind, p, POS_BITS'(1), st.line);
        use_cnt = '0;
        if (end_of_input) begin
            ex_v    = 1'b1;
            ex_tok  = make_tok(K_END, p, '0, st.line);
            use_cnt = f_cnt;
        end else if (restart) begin
            ex_v    = fi_emit;
            use_cnt = f_cnt;
        end else begin
            unique case (st.mode)
                M_PEND: begin
                    ex_v   = 1'b1;
                    ex_tok = make_tok(PEND_SHORT[st.pend_sel] + 1'b1, st.tok_begin,
                                      span_pi, st.line);
                end
                M_STR: begin
                    ex_v   = (c == quote_char);
                    ex_tok = make_tok(K_STR, st.tok_begin, span_pi, st.line);
                end
                M_AMPDASH: begin
                    ex_v   = 1'b1;
                    ex_tok = make_tok(K_AMPARROW, st.tok_begin, span_pi, st.line);
                end
                default: ex_v = 1'b0;
            endcase
        end

        push.count  = use_cnt + RES_CNT_W'(ex_v);
        push.tok[0] = (use_cnt != '0) ? f0 : ex_tok;
        push.tok[1] = (use_cnt > RES_CNT_W'(1)) ? f1 : ex_tok;
        push.tok[2] = ex_tok;
    end

endmodule

// ----- hw/rtl/stl_result_queue.sv -----
module stl_result_queue
    import stl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  stl_push_t   push,
    input  logic        pop,
    output logic        room,
    output logic        head_valid,
    output stl_entry_t  head
);

    stl_entry_t            mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RQ_CNT_W-1:0]   count_reg, count_next;
    logic                  pop_fire;

    assign pop_fire   = pop && (count_reg != '0);
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    // room for a full burst once this cycle's pop has left
    assign room = (count_reg <= RQ_CNT_W'(RQ_DEPTH - MAX_RES) + RQ_CNT_W'(pop_fire));

    assign wr_ptr_next = wr_ptr_reg + RQ_PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + RQ_PTR_W'(pop_fire);
    assign count_next  = count_reg + RQ_CNT_W'(push.count) - RQ_CNT_W'(pop_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (RES_CNT_W'(i) < push.count) begin
                mem_reg[wr_ptr_reg + RQ_PTR_W'(i)].tok  <= push.tok[i];
                mem_reg[wr_ptr_reg + RQ_PTR_W'(i)].last <= (RES_CNT_W'(i) == push.count - 1'b1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= RQ_CNT_W'(RQ_DEPTH))
        else $error("result queue over depth");

    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != '0 |->
            (32'(count_reg) + 32'(push.count)) <= (32'(RQ_DEPTH) + 32'(pop_fire)))
        else $error("burst pushed without room");

endmodule

// ----- hw/rtl/script_token_lexer.sv -----
// Streaming lexer: one source byte per item on the s_ side, tokens on the m_ side as
// kind, start offset, length and line. An item with s_tlast high is end of input: it
// flushes any held token, emits the end token (length 0) and returns the scanner to its
// reset state; its byte is ignored. Each item yields zero to three tokens, and m_tlast
// marks the last token an item caused. Throughput is one item per clock; the limit is
// the output side, which drains one token per clock from a four-entry result queue, and
// the input stalls while the queue cannot take a full three-token burst. An accepted item
// passes the input register and then the queue before m_tvalid rises, and waits in the
// input register while the queue lacks room.
module script_token_lexer
    import stl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] byte_value
    input  logic                   s_tlast,   // end_of_input

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [5:0] token_kind, [37:6] token_start, [69:38] token_length,
    // [93:70] token_line, rest zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast    // last token of the item
);

    // Input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_eoi_reg;

    // Scanner state
    stl_state_t  state_reg, state_next;

    stl_push_t   push;
    logic        room;
    logic        advance;
    logic        s_fire;
    stl_entry_t  head;
    logic        head_valid;

    // The held item is scanned once the queue can absorb its worst-case burst.
    assign advance  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    assign in_valid_next = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= ST_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tlast;
        end
    end

    // Per-byte scan: flush, rescan and state update in one pass
    stl_step u_step (
        .st           (state_reg),
        .byte_value   (in_byte_reg),
        .end_of_input (in_eoi_reg),
        .st_next      (state_next),
        .push         (push)
    );

    // Gate the burst so nothing is written while the item waits
    stl_push_t push_gated;
    always_comb begin
        push_gated = push;
        if (!advance) begin
            push_gated.count = '0;
        end
    end

    stl_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_gated),
        .pop        (m_tready),
        .room       (room),
        .head_valid (head_valid),
        .head       (head)
    );

    assign m_tvalid = head_valid;
    assign m_tlast  = head.last;
    assign m_tdata  = {{(OUT_TDATA_W - TOK_FIELDS_W){1'b0}},
                       head.tok.line, head.tok.length, head.tok.start, head.tok.kind};

    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.line != '0)
        else $error("line count reached zero");

    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_eoi_reg |=>
            state_reg.pos == $past(state_reg.pos) + 1'b1 || state_reg.pos == POS_TOP)
        else $error("byte position did not advance");

    a_eoi_end: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_eoi_reg |-> push.count != '0 ##1
            (state_reg.pos == '0 && state_reg.mode == M_IDLE))
        else $error("end of input without end token or reset");

endmodule
